// ===== sv/quaternion_to_euler_angles_top_macros.svh =====
// assertion helpers
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH

`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("q2e assertion failed");

`define Q2E_ASSERT_RANGE(lbl, vld, sig, lim) \
	`Q2E_ASSERT_IMPL(lbl, vld, (($signed(sig) <= (lim)) && ($signed(sig) >= -(lim))))

`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("q2e assertion failed");

`endif

// ===== sv/q2e_pkg.sv =====
package q2e_pkg;
	localparam int QW = 16;
	localparam int PW = 32;
	localparam int SW = 34;
	localparam int RW = 61;
	localparam int CW = 38;
	localparam int ZW = 35;
	localparam int ISQ_STEPS = 31;
	localparam int ATAN_TAB_LEN = 24;
	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [PW-1:0] ONE_Q30 = 32'sd1073741824;
	localparam int ANGLE_LIM = 25736;
	localparam int PITCH_LIM = 12868;

	typedef logic signed [QW-1:0] quat_t;
	typedef logic signed [CW-1:0] cord_t;
	typedef logic signed [ZW-1:0] ang_t;

	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] r;
		case (i)
			0: r = 30'd843314857;
			1: r = 30'd497837829;
			2: r = 30'd263043837;
			3: r = 30'd133525159;
			4: r = 30'd67021687;
			5: r = 30'd33543516;
			6: r = 30'd16775851;
			7: r = 30'd8388437;
			8: r = 30'd4194283;
			9: r = 30'd2097149;
			10: r = 30'd1048576;
			11: r = 30'd524288;
			12: r = 30'd262144;
			13: r = 30'd131072;
			14: r = 30'd65536;
			15: r = 30'd32768;
			16: r = 30'd16384;
			17: r = 30'd8192;
			18: r = 30'd4096;
			19: r = 30'd2048;
			20: r = 30'd1024;
			21: r = 30'd512;
			22: r = 30'd256;
			23: r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== sv/quaternion_to_euler_angles_top.sv =====
// Quaternion (w, x, y, z, signed Q1.15) to ZYX Euler angles roll, pitch, yaw in signed
// Q3.13 radians. Fully pipelined: one request is taken every cycle while in_stall is low, and
// each result passes through the product, sum and square registers, the 31-step
// square-root pipeline feeding the arcsine, the CORDIC_STEPS-stage vectoring CORDIC lanes
// and the output rounding register. A stalled result moves into a one-entry
// skid register and the whole pipeline freezes from the next cycle until it drains, so
// in_stall is a register output; the pitch argument is saturated to [-1, 1].
`include "quaternion_to_euler_angles_top_macros.svh"

module quaternion_to_euler_angles_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  q2e_pkg::quat_t quat_w,
	input  q2e_pkg::quat_t quat_x,
	input  q2e_pkg::quat_t quat_y,
	input  q2e_pkg::quat_t quat_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle
);
	import q2e_pkg::*;

	localparam int LAT = 3 + ISQ_STEPS + 1 + CORDIC_STEPS + 1 + 1;

	logic en;
	logic skid_q;
	logic [LAT-1:0] vld_q;
	logic signed [15:0] roll_s6, yaw_s6;
	logic signed [14:0] pitch_s6;
	logic signed [15:0] roll_skid_q, yaw_skid_q;
	logic signed [14:0] pitch_skid_q;

	assign en = !skid_q;
	assign in_stall = skid_q;
	assign out_valid = skid_q || vld_q[LAT-1];
	assign roll_angle = skid_q ? roll_skid_q : roll_s6;
	assign pitch_angle = skid_q ? pitch_skid_q : pitch_s6;
	assign yaw_angle = skid_q ? yaw_skid_q : yaw_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			skid_q <= 1'b0;
		end else begin
			skid_q <= out_valid && out_stall;
			if (en) begin
				vld_q <= {vld_q[LAT-2:0], in_valid};
			end
		end
	end

	// skid register for a stalled result
	always_ff @(posedge clk) begin
		if (!skid_q) begin
			roll_skid_q <= roll_s6;
			pitch_skid_q <= pitch_s6;
			yaw_skid_q <= yaw_s6;
		end
	end

	// products
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= PW'(quat_w) * PW'(quat_x);
			yz_s1 <= PW'(quat_y) * PW'(quat_z);
			xx_s1 <= PW'(quat_x) * PW'(quat_x);
			yy_s1 <= PW'(quat_y) * PW'(quat_y);
			wz_s1 <= PW'(quat_w) * PW'(quat_z);
			xy_s1 <= PW'(quat_x) * PW'(quat_y);
			zz_s1 <= PW'(quat_z) * PW'(quat_z);
			wy_s1 <= PW'(quat_w) * PW'(quat_y);
			zx_s1 <= PW'(quat_z) * PW'(quat_x);
		end
	end

	// sums and pitch saturation
	logic signed [SW-1:0] rn_s2, rd_s2, yn_s2, yd_s2;
	logic signed [PW-1:0] s_s2;
	logic signed [SW-1:0] s_raw;
	assign s_raw = (SW'(wy_s1) - SW'(zx_s1)) <<< 1;
	always_ff @(posedge clk) begin
		if (en) begin
			rn_s2 <= (SW'(wx_s1) + SW'(yz_s1)) <<< 1;
			rd_s2 <= SW'(ONE_Q30) - ((SW'(xx_s1) + SW'(yy_s1)) <<< 1);
			yn_s2 <= (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
			yd_s2 <= SW'(ONE_Q30) - ((SW'(yy_s1) + SW'(zz_s1)) <<< 1);
			if (s_raw > SW'(ONE_Q30)) begin
				s_s2 <= ONE_Q30;
			end else if (s_raw < -SW'(ONE_Q30)) begin
				s_s2 <= -ONE_Q30;
			end else begin
				s_s2 <= PW'(s_raw);
			end
		end
	end

	// square of the pitch argument
	logic [30:0] s_mag;
	logic [61:0] sq_full;
	logic [RW-1:0] sq_s3;
	logic signed [SW-1:0] rn_s3, rd_s3, yn_s3, yd_s3;
	logic signed [PW-1:0] s_s3;
	assign s_mag = s_s2[PW-1] ? 31'(-s_s2) : 31'(s_s2);
	assign sq_full = 62'(s_mag) * 62'(s_mag);
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= sq_full[RW-1:0];
			rn_s3 <= rn_s2;
			rd_s3 <= rd_s2;
			yn_s3 <= yn_s2;
			yd_s3 <= yd_s2;
			s_s3 <= s_s2;
		end
	end

	// bitwise square root of 1 - s*s
	logic [RW-1:0] rt_n_s4 [0:ISQ_STEPS];
	logic [RW-1:0] rt_r_s4 [0:ISQ_STEPS];
	logic signed [SW-1:0] rn_s4 [0:ISQ_STEPS];
	logic signed [SW-1:0] rd_s4 [0:ISQ_STEPS];
	logic signed [SW-1:0] yn_s4 [0:ISQ_STEPS];
	logic signed [SW-1:0] yd_s4 [0:ISQ_STEPS];
	logic signed [PW-1:0] s_s4 [0:ISQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			rt_n_s4[0] <= (RW'(1) << (RW - 1)) - sq_s3;
			rt_r_s4[0] <= '0;
			rn_s4[0] <= rn_s3;
			rd_s4[0] <= rd_s3;
			yn_s4[0] <= yn_s3;
			yd_s4[0] <= yd_s3;
			s_s4[0] <= s_s3;
		end
	end

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
		localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * k);
		logic [RW:0] trial;
		assign trial = {1'b0, rt_r_s4[k]} + {1'b0, BIT};
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rt_n_s4[k]} >= trial) begin
					rt_n_s4[k+1] <= rt_n_s4[k] - trial[RW-1:0];
					rt_r_s4[k+1] <= (rt_r_s4[k] >> 1) + BIT;
				end else begin
					rt_n_s4[k+1] <= rt_n_s4[k];
					rt_r_s4[k+1] <= rt_r_s4[k] >> 1;
				end
				rn_s4[k+1] <= rn_s4[k];
				rd_s4[k+1] <= rd_s4[k];
				yn_s4[k+1] <= yn_s4[k];
				yd_s4[k+1] <= yd_s4[k];
				s_s4[k+1] <= s_s4[k];
			end
		end
	end

	// vectoring cordic, lanes roll, pitch, yaw
	cord_t cx_s5 [0:CORDIC_STEPS][3];
	cord_t cy_s5 [0:CORDIC_STEPS][3];
	ang_t cz_s5 [0:CORDIC_STEPS][3];
	logic zr_s5 [0:CORDIC_STEPS][3];

	cord_t lane_x [3];
	cord_t lane_y [3];
	assign lane_x[0] = CW'(rd_s4[ISQ_STEPS]);
	assign lane_y[0] = CW'(rn_s4[ISQ_STEPS]);
	assign lane_x[1] = CW'({1'b0, rt_r_s4[ISQ_STEPS][30:0]});
	assign lane_y[1] = CW'(s_s4[ISQ_STEPS]);
	assign lane_x[2] = CW'(yd_s4[ISQ_STEPS]);
	assign lane_y[2] = CW'(yn_s4[ISQ_STEPS]);

	for (genvar l = 0; l < 3; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				zr_s5[0][l] <= (lane_x[l] == '0) && (lane_y[l] == '0);
				if (lane_x[l] < 0) begin
					cz_s5[0][l] <= (lane_y[l] >= 0) ? PI_Q30 : -PI_Q30;
					cx_s5[0][l] <= -lane_x[l];
					cy_s5[0][l] <= -lane_y[l];
				end else begin
					cz_s5[0][l] <= '0;
					cx_s5[0][l] <= lane_x[l];
					cy_s5[0][l] <= lane_y[l];
				end
			end
		end

		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
			localparam ang_t ATAN = ZW'(atan_q30(i));
			cord_t xs, ys;
			assign xs = cx_s5[i][l] >>> i;
			assign ys = cy_s5[i][l] >>> i;
			always_ff @(posedge clk) begin
				if (en) begin
					zr_s5[i+1][l] <= zr_s5[i][l];
					if (cy_s5[i][l] < 0) begin
						cx_s5[i+1][l] <= cx_s5[i][l] - ys;
						cy_s5[i+1][l] <= cy_s5[i][l] + xs;
						cz_s5[i+1][l] <= cz_s5[i][l] - ATAN;
					end else begin
						cx_s5[i+1][l] <= cx_s5[i][l] + ys;
						cy_s5[i+1][l] <= cy_s5[i][l] - xs;
						cz_s5[i+1][l] <= cz_s5[i][l] + ATAN;
					end
				end
			end
		end
	end

	// round to Q3.13 and saturate
	function automatic logic signed [15:0] to_q13(input ang_t z, input logic zr,
			input logic [14:0] lim);
		logic [ZW-1:0] m;
		logic [ZW-1:0] q;
		logic [14:0] r;
		m = z[ZW-1] ? ZW'(-z) : ZW'(z);
		q = (m + (ZW'(1) << 16)) >> 17;
		r = (q > ZW'(lim)) ? lim : q[14:0];
		if (zr) begin
			return '0;
		end
		return z[ZW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	logic signed [15:0] pitch_full;
	assign pitch_full = to_q13(cz_s5[CORDIC_STEPS][1], zr_s5[CORDIC_STEPS][1],
		15'(PITCH_LIM));

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s6 <= to_q13(cz_s5[CORDIC_STEPS][0], zr_s5[CORDIC_STEPS][0],
				15'(ANGLE_LIM));
			pitch_s6 <= pitch_full[14:0];
			yaw_s6 <= to_q13(cz_s5[CORDIC_STEPS][2], zr_s5[CORDIC_STEPS][2],
				15'(ANGLE_LIM));
		end
	end

	`Q2E_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_q[0])
	`Q2E_ASSERT_RANGE(a_roll_range, out_valid, roll_angle, ANGLE_LIM)
	`Q2E_ASSERT_RANGE(a_yaw_range, out_valid, yaw_angle, ANGLE_LIM)
	`Q2E_ASSERT_RANGE(a_pitch_range, out_valid, pitch_angle, PITCH_LIM)
endmodule

// ===== verif/tb_quaternion_to_euler_angles_top.sv =====
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles_top;
	import q2e_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = 3 + 32 + STEPS + 1 + 1;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ONE = 64'sd1073741824;
	localparam longint PI_FIX = 64'sd3373259426;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	quat_t quat_w, quat_x, quat_y, quat_z;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} euler_t;

	euler_t euler_queue[$];
	int errors = 0;
	longint cycles = 0;
	int hold_cycles = 0;
	bit hold_request = 0;
	bit random_stall = 0;

	localparam longint ATAN_FIX[24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128};

	quaternion_to_euler_angles_top #(.CORDIC_STEPS(STEPS)) uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_stall(out_stall), .roll_angle(roll_angle),
		.pitch_angle(pitch_angle), .yaw_angle(yaw_angle)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, xs, ys;
		int n;
		z = 0;
		n = (STEPS > 24) ? 24 : STEPS;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_FIX : -PI_FIX;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < n; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_FIX[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_FIX[i];
			end
		end
		return z;
	endfunction

	function automatic longint round_angle(longint z, longint lim);
		longint m;
		m = (z < 0) ? -z : z;
		m = (m + (64'sd1 <<< 16)) >>> 17;
		if (m > lim)
			m = lim;
		return (z < 0) ? -m : m;
	endfunction

	function automatic euler_t predict_euler(quat_t qw, quat_t qx, quat_t qy, quat_t qz);
		longint w, x, y, z, rn, rd, yn, yd, s, c;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		rn = 2 * (w * x + y * z);
		rd = ONE - 2 * (x * x + y * y);
		yn = 2 * (w * z + x * y);
		yd = ONE - 2 * (y * y + z * z);
		s = 2 * (w * y - z * x);
		if (s > ONE) s = ONE;
		if (s < -ONE) s = -ONE;
		c = root_floor((64'sd1 <<< 60) - s * s);
		e.roll = 16'(round_angle(vector_angle(rn, rd), ANGLE_LIM));
		e.pitch = 15'(round_angle(vector_angle(s, c), PITCH_LIM));
		e.yaw = 16'(round_angle(vector_angle(yn, yd), ANGLE_LIM));
		return e;
	endfunction

	task automatic send_request(quat_t w, quat_t x, quat_t y, quat_t z, bit gaps);
		int g;
		if (gaps) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
			if (g > 0) begin
				in_valid <= 0;
				repeat (g) @(posedge clk);
			end
		end
		in_valid <= 1;
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		euler_queue.push_back(predict_euler(w, x, y, z));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (euler_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		quat_t v[6] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5A82};
		send_request(16'sh7FFF, 0, 0, 0, 0);
		send_request(0, 0, 0, 0, 0);
		send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
		send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
		send_request(16'sh5A82, 0, 16'sh5A82, 0, 0);
		send_request(16'sh5A82, 0, 16'shA57E, 0, 0);
		send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 0);
		send_request(0, 16'sh7FFF, 0, 0, 0);
		send_request(0, 0, 16'sh7FFF, 0, 0);
		send_request(0, 0, 0, 16'sh7FFF, 0);
		send_request(0, 16'sh7FFF, 16'sh7FFF, 0, 0);
		for (int i = 0; i < 12; i++)
			send_request(v[i % 6], v[(i + 1) % 6], v[(i + 3) % 6], v[(i + 5) % 6], 0);
		wait_drained();
	endtask

	task automatic test_random(int n);
		quat_t w, x, y, z;
		for (int i = 0; i < n; i++) begin
			w = 16'($urandom); x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
			if (i % 4 == 1) begin
				w = w >>> 1; x = x >>> 1; y = y >>> 1; z = z >>> 1;
			end
			send_request(w, x, y, z, (i % 100) < 70);
		end
	endtask

	task automatic test_backpressure();
		hold_request <= 1;
		@(posedge clk);
		hold_request <= 0;
		for (int i = 0; i < 80; i++)
			send_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 0);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			out_stall <= 1;
			hold_cycles <= 150;
		end else if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else if (random_stall) begin
			if ($urandom_range(0, 49) == 0)
				hold_cycles <= $urandom_range(10, 40);
			out_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		euler_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (euler_queue.size() == 0) begin
				$display("%0t: unexpected result roll %0d pitch %0d yaw %0d",
					$time, roll_angle, pitch_angle, yaw_angle);
				errors++;
			end else begin
				e = euler_queue.pop_front();
				if (roll_angle !== e.roll) begin
					$display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_angle);
					errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
						pitch_angle);
					errors++;
				end
				if (yaw_angle !== e.yaw) begin
					$display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_angle);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		random_stall <= 1;
		test_random(200);
		wait_drained();
		test_backpressure();
		random_stall <= 1;
		test_random(150);
		random_stall <= 0;
		test_random(100);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
